FILE: hdl/fast_float_log2_approx_assert.svh
// Assertion shorthands for the log2 block checkers.
// All of them sample on i_clk; the first two are masked while reset is low.
`ifndef FAST_FLOAT_LOG2_APPROX_ASSERT_SVH
`define FAST_FLOAT_LOG2_APPROX_ASSERT_SVH

// same-cycle implication
`define FFL2_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFL2_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define FFL2_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/ffl2_pkg.sv
package ffl2_pkg;

    // binary32 patterns
    localparam logic [31:0] F32_POS_INF = 32'h7F80_0000;
    localparam logic [31:0] F32_NEG_INF = 32'hFF80_0000;
    localparam logic [31:0] F32_QNAN    = 32'h7FC0_0000;
    localparam logic [31:0] F32_ONE     = 32'h3F80_0000;
    localparam logic [31:0] F32_NEG_ONE = 32'hBF80_0000;

    // cubic coefficients, rounded to binary32
    localparam logic [31:0] COEF2 = 32'h3E51_5A4B;   //  0.204446
    localparam logic [31:0] COEF1 = 32'hBF23_E6AC;   // -0.640239
    localparam logic [31:0] COEF0 = 32'h3FB8_24A5;   //  1.438618

    localparam logic [7:0] EXP_BIAS = 8'd127;

    // data that rides alongside each item through the arithmetic units
    typedef struct packed {
        logic [31:0] f;          // mantissa minus one, as binary32
        logic [31:0] ipart;      // unbiased exponent, as binary32
        logic        spec_en;    // special operand: override result
        logic [31:0] spec_val;
    } t_side;

    // exact conversion of (expf - 127) to binary32; range is -127..128
    function automatic logic [31:0] exp_to_f32(input logic [7:0] expf);
        logic       sgn;
        logic [7:0] mag;
        logic [2:0] msb;
        logic [7:0] norm;
        logic [31:0] res;
        sgn = (expf < EXP_BIAS);
        mag = sgn ? (EXP_BIAS - expf) : (expf - EXP_BIAS);
        msb = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (mag[i]) msb = 3'(i);
        end
        norm = mag << (3'd7 - msb);
        if (mag == 8'd0) begin
            res = 32'd0;
        end else begin
            res = {sgn, EXP_BIAS + {5'd0, msb}, norm[6:0], 16'd0};
        end
        return res;
    endfunction

endpackage

FILE: hdl/ffl2_fadd.sv
// Three-stage binary32 adder, round to nearest even.
// Operands are normal numbers or zeros; results stay in the normal range.
module ffl2_fadd import ffl2_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [31:0] o_res,
    output t_side       o_side
);

    // stage 1: order by magnitude, align, add
    logic        n_swap;
    logic [31:0] n_big, n_sml;
    logic [23:0] n_big_sig, n_sml_sig;
    logic [7:0]  n_diff;
    logic [4:0]  n_dc;
    logic [58:0] n_wide;
    logic [26:0] n_sml27, n_big27;
    logic [27:0] n_sum;

    always_comb begin
        n_swap    = (i_b[30:0] > i_a[30:0]);
        n_big     = n_swap ? i_b : i_a;
        n_sml     = n_swap ? i_a : i_b;
        n_big_sig = {|n_big[30:23], n_big[22:0]};
        n_sml_sig = {|n_sml[30:23], n_sml[22:0]};
        n_diff    = n_big[30:23] - n_sml[30:23];
        n_dc      = (n_diff > 8'd31) ? 5'd31 : n_diff[4:0];
        n_wide    = {n_sml_sig, 3'b000, 32'd0} >> n_dc;
        n_sml27   = {n_wide[58:33], n_wide[32] | (|n_wide[31:0])};
        n_big27   = {n_big_sig, 3'b000};
        if (n_big[31] ^ n_sml[31]) begin
            n_sum = {1'b0, n_big27} - {1'b0, n_sml27};
        end else begin
            n_sum = {1'b0, n_big27} + {1'b0, n_sml27};
        end
    end

    logic        r1_vld, r1_sign, r1_zsign;
    logic [7:0]  r1_exp;
    logic [27:0] r1_sum;
    t_side       r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sign  <= n_big[31];
            r1_zsign <= i_a[31] & i_b[31];
            r1_exp   <= n_big[30:23];
            r1_sum   <= n_sum;
            r1_side  <= i_side;
        end
    end

    // stage 2: leading zero count
    logic [4:0] n_lz;

    always_comb begin
        n_lz = 5'd0;
        for (int i = 0; i < 28; i++) begin
            if (r1_sum[i]) n_lz = 5'(27 - i);
        end
    end

    logic        r2_vld, r2_sign, r2_zsign;
    logic [7:0]  r2_exp;
    logic [27:0] r2_sum;
    logic [4:0]  r2_lz;
    t_side       r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sign  <= r1_sign;
            r2_zsign <= r1_zsign;
            r2_exp   <= r1_exp;
            r2_sum   <= r1_sum;
            r2_lz    <= n_lz;
            r2_side  <= r1_side;
        end
    end

    // stage 3: normalize and round
    logic [27:0] n_norm;
    logic [9:0]  n_exp;
    logic        n_inc;
    logic [23:0] n_m24;
    logic [31:0] n_res;

    always_comb begin
        n_norm = r2_sum << r2_lz;
        n_inc  = n_norm[3] & ((|n_norm[2:0]) | n_norm[4]);
        n_m24  = {1'b0, n_norm[26:4]} + {23'd0, n_inc};
        n_exp  = {2'b00, r2_exp} + 10'd1 - {5'd0, r2_lz} + {9'd0, n_m24[23]};
        if (r2_sum == 28'd0) begin
            n_res = {r2_zsign, 31'd0};
        end else begin
            n_res = {r2_sign, n_exp[7:0], n_m24[22:0]};
        end
    end

    logic        r3_vld;
    logic [31:0] r3_res;
    t_side       r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_res  <= n_res;
            r3_side <= r2_side;
        end
    end

    assign o_vld  = r3_vld;
    assign o_res  = r3_res;
    assign o_side = r3_side;

endmodule

FILE: hdl/ffl2_fmul.sv
// Two-stage binary32 multiplier, round to nearest even.
// Operands are normal numbers or zeros; results stay in the normal range.
module ffl2_fmul import ffl2_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [31:0] o_res,
    output t_side       o_side
);

    // stage 1: significand product
    logic        r1_vld, r1_sign, r1_zero;
    logic [9:0]  r1_exp;
    logic [47:0] r1_prod;
    t_side       r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sign <= i_a[31] ^ i_b[31];
            r1_zero <= (i_a[30:23] == 8'd0) | (i_b[30:23] == 8'd0);
            r1_exp  <= {2'b00, i_a[30:23]} + {2'b00, i_b[30:23]} - {2'b00, EXP_BIAS};
            r1_prod <= {1'b1, i_a[22:0]} * {1'b1, i_b[22:0]};
            r1_side <= i_side;
        end
    end

    // stage 2: normalize by one place and round
    logic        n_hi, n_g, n_st, n_inc;
    logic [22:0] n_mant;
    logic [23:0] n_m24;
    logic [9:0]  n_exp;
    logic [31:0] n_res;

    always_comb begin
        n_hi   = r1_prod[47];
        n_mant = n_hi ? r1_prod[46:24] : r1_prod[45:23];
        n_g    = n_hi ? r1_prod[23] : r1_prod[22];
        n_st   = n_hi ? (|r1_prod[22:0]) : (|r1_prod[21:0]);
        n_inc  = n_g & (n_st | n_mant[0]);
        n_m24  = {1'b0, n_mant} + {23'd0, n_inc};
        n_exp  = r1_exp + {9'd0, n_hi} + {9'd0, n_m24[23]};
        if (r1_zero) begin
            n_res = {r1_sign, 31'd0};
        end else begin
            n_res = {r1_sign, n_exp[7:0], n_m24[22:0]};
        end
    end

    logic        r2_vld;
    logic [31:0] r2_res;
    t_side       r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_res  <= n_res;
            r2_side <= r1_side;
        end
    end

    assign o_vld  = r2_vld;
    assign o_res  = r2_res;
    assign o_side = r2_side;

endmodule

FILE: hdl/fast_float_log2_approx.sv
// Approximate log2 of a binary32 operand, one operand per clock, fully pipelined.
// Result = exponent - 127 + ((c2*f + c1)*f + c0)*f with f = 1.frac - 1, every step
// rounded to binary32 (nearest even). Zero gives -inf, negative gives quiet NaN,
// +inf gives +inf, NaN gives quiet NaN. From input transfer to output valid an item
// passes four three-stage adders, three two-stage multipliers and an output
// register. While the output is stalled the whole pipeline holds.
module fast_float_log2_approx import ffl2_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_operand_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_log2_bits
);

    logic        en;
    logic        r_out_vld;
    logic [31:0] r_out_bits;

    // pipeline advances unless a held result is blocked
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    // operand classification and exponent conversion
    logic [30:0] n_mag;
    logic        n_nan, n_zero, n_neg, n_pinf;
    t_side       n_side0;

    always_comb begin
        n_mag  = i_operand_bits[30:0];
        n_nan  = (n_mag > F32_POS_INF[30:0]);
        n_zero = (n_mag == 31'd0);
        n_neg  = i_operand_bits[31] & !n_zero & !n_nan;
        n_pinf = (i_operand_bits == F32_POS_INF);
        n_side0.f        = 32'd0;
        n_side0.ipart    = exp_to_f32(i_operand_bits[30:23]);
        n_side0.spec_en  = n_nan | n_zero | n_neg | n_pinf;
        if (n_nan) begin
            n_side0.spec_val = F32_QNAN;
        end else if (n_pinf) begin
            n_side0.spec_val = F32_POS_INF;
        end else if (n_neg) begin
            n_side0.spec_val = F32_QNAN;
        end else begin
            n_side0.spec_val = F32_NEG_INF;
        end
    end

    logic        v0, v1, v2, v3, v4, v5, v6;
    logic [31:0] res0, res1, res2, res3, res4, res5, res6;
    t_side       s0, s1, s2, s3, s4, s5, s6;
    t_side       s0f;

    // f = 1.frac - 1.0
    ffl2_fadd u_add_f (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_a(F32_ONE | {9'd0, i_operand_bits[22:0]}), .i_b(F32_NEG_ONE),
        .i_side(n_side0), .o_vld(v0), .o_res(res0), .o_side(s0)
    );

    always_comb begin
        s0f   = s0;
        s0f.f = res0;
    end

    // t = f * c2
    ffl2_fmul u_mul_c2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v0),
        .i_a(res0), .i_b(COEF2), .i_side(s0f),
        .o_vld(v1), .o_res(res1), .o_side(s1)
    );

    // t = t + c1
    ffl2_fadd u_add_c1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v1),
        .i_a(res1), .i_b(COEF1), .i_side(s1),
        .o_vld(v2), .o_res(res2), .o_side(s2)
    );

    // t = f * t
    ffl2_fmul u_mul_f1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v2),
        .i_a(s2.f), .i_b(res2), .i_side(s2),
        .o_vld(v3), .o_res(res3), .o_side(s3)
    );

    // t = t + c0
    ffl2_fadd u_add_c0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v3),
        .i_a(res3), .i_b(COEF0), .i_side(s3),
        .o_vld(v4), .o_res(res4), .o_side(s4)
    );

    // t = t * f
    ffl2_fmul u_mul_f2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v4),
        .i_a(res4), .i_b(s4.f), .i_side(s4),
        .o_vld(v5), .o_res(res5), .o_side(s5)
    );

    // t = t + integer part
    ffl2_fadd u_add_ip (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v5),
        .i_a(res5), .i_b(s5.ipart), .i_side(s5),
        .o_vld(v6), .o_res(res6), .o_side(s6)
    );

    // output register with special-case override
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_bits <= s6.spec_en ? s6.spec_val : res6;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_log2_bits = r_out_bits;

endmodule

FILE: hdl/ffl2_chk.sv
`include "fast_float_log2_approx_assert.svh"

module ffl2_chk import ffl2_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_log2_bits
);

    logic out_blk;
    logic out_nan;

    // result waiting on a stalled receiver
    assign out_blk = o_valid && i_stall;

    // result carries a NaN pattern
    assign out_nan = o_valid && (o_log2_bits[30:23] == 8'hFF) && (o_log2_bits[22:0] != 23'd0);

    // a blocked result holds until transferred
    `FFL2_ASSERT_NEXT(a_out_hold, out_blk, o_valid && $stable(o_log2_bits), "held result changed")

    // input side stalls only behind a blocked result
    `FFL2_ASSERT_NOW(a_stall_cause, o_stall, out_blk, "input stall without blocked result")

    // any NaN produced is the canonical quiet NaN
    `FFL2_ASSERT_NOW(a_qnan_only, out_nan, o_log2_bits == F32_QNAN, "non-canonical NaN")

    // reset empties the pipeline
    `FFL2_ASSERT_RST(a_rst_empty, !i_rst_n, !o_valid, "valid right after reset")

endmodule

bind fast_float_log2_approx ffl2_chk u_ffl2_chk (.*);
